FILE: design/pps_pkg.sv
// Shared types and constants of the preemptive priority scheduler.
// Depends on nothing; every other file of the block imports it.
package pps_pkg;

   localparam int TIME_W     = 16;
   localparam int PRI_W      = 8;
   localparam int SUM_W      = 20;
   localparam int DONE_W     = 4;
   localparam int SLOT_FW    = 3;
   localparam int COUNT_W    = 4;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd8;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic [TIME_W-1:0] TIME_MAX = '1;
   localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
   localparam logic [DONE_W-1:0] DONE_MAX = '1;

   // One process slot as kept in the slot memory
   typedef struct packed {
      logic [PRI_W-1:0]  pri;
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] burst;
      logic [TIME_W-1:0] remaining;
   } entry_type;

   // One result beat
   typedef struct packed {
      logic [SLOT_FW-1:0] running_slot;
      logic               idle;
      logic               new_segment;
      logic [TIME_W-1:0]  segment_start;
      logic               finished;
      logic [TIME_W-1:0]  finish_time;
      logic [TIME_W-1:0]  turnaround;
      logic [TIME_W-1:0]  waiting;
      logic [SUM_W-1:0]   total_turnaround;
      logic [SUM_W-1:0]   total_waiting;
      logic               all_done;
   } result_type;

endpackage

FILE: design/pps_channels.sv
// Valid/ready channel interfaces for request and response beats.
// Depends on pps_pkg for field widths.
interface pps_req_if;
   import pps_pkg::*;
   logic               valid;
   logic               ready;
   logic               command;
   logic [SLOT_FW-1:0] slot;
   logic [PRI_W-1:0]   priority_req;
   logic [TIME_W-1:0]  arrival;
   logic [TIME_W-1:0]  burst;

   modport source (output valid, command, slot, priority_req, arrival, burst, input ready);
   modport sink   (input valid, command, slot, priority_req, arrival, burst, output ready);
endinterface

interface pps_rsp_if;
   import pps_pkg::*;
   logic               valid;
   logic               ready;
   logic [SLOT_FW-1:0] running_slot;
   logic               idle;
   logic               new_segment;
   logic [TIME_W-1:0]  segment_start;
   logic               finished;
   logic [TIME_W-1:0]  finish_time;
   logic [TIME_W-1:0]  turnaround;
   logic [TIME_W-1:0]  waiting;
   logic [SUM_W-1:0]   total_turnaround;
   logic [SUM_W-1:0]   total_waiting;
   logic               all_done;

   modport source (output valid, running_slot, idle, new_segment, segment_start, finished,
                   finish_time, turnaround, waiting, total_turnaround, total_waiting,
                   all_done, input ready);
   modport sink   (input valid, running_slot, idle, new_segment, segment_start, finished,
                   finish_time, turnaround, waiting, total_turnaround, total_waiting,
                   all_done, output ready);
endinterface

FILE: design/pps_store.sv
// Slot memory: one write and one read port, registered read data.
// Per-entry valid bits make unwritten entries read as all zero. Uses pps_pkg.
module pps_store #(
   parameter int DEPTH  = 8,
   parameter int ADDR_W = 3
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  pps_pkg::entry_type  wr_data,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output pps_pkg::entry_type  rd_data
);
   import pps_pkg::*;

   entry_type              mem [DEPTH];
   logic [DEPTH-1:0]       vld_ff;
   entry_type              rd_ff;
   logic                   rd_vld_ff;

   // Mark entries written since reset
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   // Write and read the array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // Blank entries that were never written
   assign rd_data = rd_vld_ff ? rd_ff : '0;

endmodule

FILE: design/pps_out.sv
// Output register of the response channel; holds one beat until taken.
// Uses pps_pkg and the pps_rsp_if interface.
module pps_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  pps_pkg::result_type data,
   output logic                free,
   pps_rsp_if.source           rsp_bus
);
   import pps_pkg::*;

   logic       valid_ff;
   result_type data_ff;

   assign free = !valid_ff || rsp_bus.ready;

   // Hold the beat until the sink takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data;
      end
   end

   assign rsp_bus.valid            = valid_ff;
   assign rsp_bus.running_slot     = data_ff.running_slot;
   assign rsp_bus.idle             = data_ff.idle;
   assign rsp_bus.new_segment      = data_ff.new_segment;
   assign rsp_bus.segment_start    = data_ff.segment_start;
   assign rsp_bus.finished         = data_ff.finished;
   assign rsp_bus.finish_time      = data_ff.finish_time;
   assign rsp_bus.turnaround       = data_ff.turnaround;
   assign rsp_bus.waiting          = data_ff.waiting;
   assign rsp_bus.total_turnaround = data_ff.total_turnaround;
   assign rsp_bus.total_waiting    = data_ff.total_waiting;
   assign rsp_bus.all_done         = data_ff.all_done;

endmodule

FILE: design/preemptive_priority_scheduler.sv
// Preemptive priority scheduler. A load beat writes one slot. A tick beat scans the first
// min(process_count, PROCESSES) slots, applies the winner and updates the totals when
// the chosen slot completes: the slot memory has one read port, so the scan reads one slot per
// cycle, and the winner is written back with one less unit of work. One beat is in work at a
// time; a finished response waits in the output register while the next request is taken.
// Depends on pps_pkg, pps_channels, pps_store and pps_out.
module preemptive_priority_scheduler #(
   parameter int PROCESSES = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [pps_pkg::COUNT_W-1:0] csr_wdata,
   pps_req_if.sink                  req_bus,
   pps_rsp_if.source                rsp_bus
);
   import pps_pkg::*;

   localparam int SLOT_W = $clog2(PROCESSES);
   localparam int LIM_W  = $clog2(PROCESSES + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_APPLY, ST_TOTAL, ST_SUM, ST_SEND
   } state_type;

   state_type             state_ff;
   logic [COUNT_W-1:0]    count_ff;
   logic [TIME_W-1:0]     time_ff;
   logic [TIME_W-1:0]     time_in;
   logic [SLOT_W-1:0]     last_slot_ff;
   logic                  last_valid_ff;
   logic [DONE_W-1:0]     done_ff;
   logic [SUM_W-1:0]      sum_tat_ff;
   logic [SUM_W-1:0]      sum_wt_ff;
   logic [LIM_W-1:0]      limit_ff;
   logic [LIM_W-1:0]      limit_in;
   logic [LIM_W-1:0]      iss_ff;
   logic                  pend_ff;
   logic [SLOT_W-1:0]     pend_idx_ff;
   logic                  found_ff;
   logic [SLOT_W-1:0]     best_idx_ff;
   entry_type             best_ff;
   result_type            res_ff;
   result_type            res_out;

   logic                  accept;
   logic                  issue;
   logic                  eligible;
   logic                  load_ok;
   logic                  wr_en;
   logic [SLOT_W-1:0]     wr_addr;
   entry_type             wr_data;
   entry_type             rd_data;
   logic                  out_free;
   logic                  out_load;
   logic [TIME_W-1:0]     wait_in;
   logic [SUM_W:0]        sum_tat_raw;
   logic [SUM_W:0]        sum_wt_raw;

   pps_store #(.DEPTH(PROCESSES), .ADDR_W(SLOT_W)) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (iss_ff[SLOT_W-1:0]),
      .rd_data (rd_data)
   );

   pps_out u_out (
      .clock   (clock),
      .reset   (reset),
      .load    (out_load),
      .data    (res_out),
      .free    (out_free),
      .rsp_bus (rsp_bus)
   );

   // Process count register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else if (csr_we) begin
         count_ff <= csr_wdata;
      end
   end

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign load_ok       = (32'(req_bus.slot) < PROCESSES);

   // Scan: one read per cycle, data compared in the cycle after the read
   assign issue    = (state_ff == ST_SCAN) && (iss_ff < limit_ff);
   assign eligible = pend_ff && (rd_data.arrival <= time_ff) && (rd_data.remaining != '0)
                     && (!found_ff || (rd_data.pri < best_ff.pri));

   // Saturating time advance and scan bound
   always_comb begin
      time_in  = (time_ff == TIME_MAX) ? time_ff : time_ff + 1'b1;
      limit_in = (32'(count_ff) < PROCESSES) ? LIM_W'(count_ff) : LIM_W'(PROCESSES);
   end

   // Memory write: a load at accept, or the winner written back after the scan.
   // Only one beat is in work, so a write never overlaps a read of the same entry.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = best_idx_ff;
      wr_data = best_ff;
      wr_data.remaining = best_ff.remaining - 1'b1;
      if (accept && (req_bus.command == CMD_LOAD)) begin
         wr_en           = load_ok;
         wr_addr         = SLOT_W'(req_bus.slot);
         wr_data.pri       = req_bus.priority_req;
         wr_data.arrival   = req_bus.arrival;
         wr_data.burst     = req_bus.burst;
         wr_data.remaining = req_bus.burst;
      end else if ((state_ff == ST_APPLY) && found_ff) begin
         wr_en = 1'b1;
      end
   end

   // Waiting time and saturating totals
   always_comb begin
      wait_in     = (res_ff.turnaround > best_ff.burst) ?
                    res_ff.turnaround - best_ff.burst : '0;
      sum_tat_raw = {1'b0, sum_tat_ff} + (SUM_W + 1)'(res_ff.turnaround);
      sum_wt_raw  = {1'b0, sum_wt_ff} + (SUM_W + 1)'(res_ff.waiting);
   end

   // Response beat: totals and completion flag as they stand now
   always_comb begin
      res_out                  = res_ff;
      res_out.total_turnaround = sum_tat_ff;
      res_out.total_waiting    = sum_wt_ff;
      res_out.all_done         = (done_ff == count_ff);
   end

   assign out_load = (state_ff == ST_SEND) && out_free;

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         time_ff       <= '0;
         last_slot_ff  <= '0;
         last_valid_ff <= 1'b0;
         done_ff       <= '0;
         sum_tat_ff    <= '0;
         sum_wt_ff     <= '0;
         iss_ff        <= '0;
         limit_ff      <= '0;
         pend_ff       <= 1'b0;
         found_ff      <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  res_ff      <= '{idle: 1'b1, default: '0};
                  iss_ff      <= '0;
                  limit_ff    <= limit_in;
                  pend_ff     <= 1'b0;
                  found_ff    <= 1'b0;
                  state_ff    <= (req_bus.command == CMD_TICK) ? ST_SCAN : ST_SEND;
               end
            end
            ST_SCAN: begin
               pend_ff     <= issue;
               pend_idx_ff <= iss_ff[SLOT_W-1:0];
               if (issue) begin
                  iss_ff <= iss_ff + 1'b1;
               end
               if (eligible) begin
                  found_ff    <= 1'b1;
                  best_idx_ff <= pend_idx_ff;
                  best_ff     <= rd_data;
               end
               if (!issue && !pend_ff) begin
                  state_ff <= ST_APPLY;
               end
            end
            ST_APPLY: begin
               time_ff  <= time_in;
               if (found_ff) begin
                  res_ff.idle          <= 1'b0;
                  res_ff.running_slot  <= SLOT_FW'(best_idx_ff);
                  res_ff.segment_start <= time_ff;
                  res_ff.new_segment   <= !last_valid_ff || (last_slot_ff != best_idx_ff);
                  last_slot_ff         <= best_idx_ff;
                  last_valid_ff        <= 1'b1;
                  if (best_ff.remaining == TIME_W'(1)) begin
                     res_ff.finished    <= 1'b1;
                     res_ff.finish_time <= time_in;
                     res_ff.turnaround  <= time_in - best_ff.arrival;
                     state_ff           <= ST_TOTAL;
                  end else begin
                     state_ff <= ST_SEND;
                  end
               end else begin
                  state_ff <= ST_SEND;
               end
            end
            ST_TOTAL: begin
               res_ff.waiting <= wait_in;
               sum_tat_ff     <= sum_tat_raw[SUM_W] ? SUM_MAX : sum_tat_raw[SUM_W-1:0];
               state_ff       <= ST_SUM;
            end
            ST_SUM: begin
               sum_wt_ff <= sum_wt_raw[SUM_W] ? SUM_MAX : sum_wt_raw[SUM_W-1:0];
               if (done_ff != DONE_MAX) begin
                  done_ff <= done_ff + 1'b1;
               end
               state_ff <= ST_SEND;
            end
            ST_SEND: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // No memory write may land while the scan reads
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !wr_en)
      else $error("slot memory written during scan");

   // A chosen slot lies inside the scanned range
   assert property (@(posedge clock) disable iff (reset)
      found_ff |-> (LIM_W'(best_idx_ff) < limit_ff))
      else $error("winning slot outside scan range");

   // Time never runs backward
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (time_ff >= $past(time_ff)))
      else $error("current time decreased");

   // A read is only outstanding while scanning
   assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == ST_SCAN))
      else $error("read pending outside scan");

endmodule

FILE: verif/pps_schedule_monitor.sv
// Scoreboard for the preemptive priority scheduler: watches the request, response and
// register ports, predicts every response beat and compares it field by field.
// Depends on pps_pkg and the channel interfaces of pps_channels.
module pps_schedule_monitor #(
   parameter int PROCESSES = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [pps_pkg::COUNT_W-1:0] csr_wdata,
   pps_req_if                          req_mon,
   pps_rsp_if                          rsp_mon,
   output int                          mismatch_count,
   output int                          runs_outstanding,
   output int                          completions
);
   import pps_pkg::*;

   localparam int PRINT_CAP = 40;

   // Shadow of the slot memory and the scheduling state
   logic [PRI_W-1:0]   slot_pri     [PROCESSES];
   logic [TIME_W-1:0]  slot_arrival [PROCESSES];
   logic [TIME_W-1:0]  slot_burst   [PROCESSES];
   logic [TIME_W-1:0]  slot_left    [PROCESSES];
   logic [TIME_W-1:0]  sched_time;
   logic [SLOT_FW-1:0] prev_slot;
   logic               prev_valid;
   logic [DONE_W-1:0]  done_n;
   logic [SUM_W-1:0]   tat_total;
   logic [SUM_W-1:0]   wait_total;
   logic [COUNT_W-1:0] slots_active;
   int                 rsp_beats;

   // Results predicted for accepted requests, oldest first
   result_type predicted_runs[$];

   task automatic log_mismatch(input string what);
      if (mismatch_count < PRINT_CAP)
         $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic match_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         log_mismatch($sformatf("%s got 0x%0h expected 0x%0h on response beat %0d",
                                name, got, want, rsp_beats));
   endtask

   // Add with a ceiling at the largest running total
   function automatic logic [SUM_W-1:0] add_capped(input logic [SUM_W-1:0] acc,
                                                   input logic [TIME_W-1:0] inc);
      logic [SUM_W:0] wide;
      wide = {1'b0, acc} + (SUM_W+1)'(inc);
      return (wide > {1'b0, SUM_MAX}) ? SUM_MAX : wide[SUM_W-1:0];
   endfunction

   // Apply one request beat to the shadow state and build the response it causes
   task automatic advance_schedule(input logic cmd, input logic [SLOT_FW-1:0] slot,
                                   input logic [PRI_W-1:0] pri,
                                   input logic [TIME_W-1:0] arrival,
                                   input logic [TIME_W-1:0] burst,
                                   output result_type run);
      int                 limit;
      logic               found;
      logic [SLOT_FW-1:0] pick;
      logic [PRI_W-1:0]   pick_pri;
      logic [TIME_W-1:0]  tat;
      run = '0;
      run.idle = 1'b1;
      found = 1'b0;
      pick = '0;
      pick_pri = '0;
      if (cmd == CMD_LOAD) begin
         if (int'(slot) < PROCESSES) begin
            slot_pri[slot] = pri;
            slot_arrival[slot] = arrival;
            slot_burst[slot] = burst;
            slot_left[slot] = burst;
         end
      end else begin
         // scan never goes past the slots that exist
         limit = (int'(slots_active) < PROCESSES) ? int'(slots_active) : PROCESSES;
         for (int i = 0; i < limit; i++) begin
            if (slot_arrival[i] <= sched_time && slot_left[i] != '0 &&
                (!found || slot_pri[i] < pick_pri)) begin
               found = 1'b1;
               pick = SLOT_FW'(i);
               pick_pri = slot_pri[i];
            end
         end
         if (found) begin
            run.idle = 1'b0;
            run.running_slot = pick;
            run.segment_start = sched_time;
            run.new_segment = !prev_valid || prev_slot != pick;
            prev_slot = pick;
            prev_valid = 1'b1;
            slot_left[pick] = slot_left[pick] - 1'b1;
         end
         // time moves on every tick, idle or not, and sticks at its ceiling
         if (sched_time != TIME_MAX)
            sched_time = sched_time + 1'b1;
         if (found && slot_left[pick] == '0) begin
            tat = sched_time - slot_arrival[pick];
            run.finished = 1'b1;
            run.finish_time = sched_time;
            run.turnaround = tat;
            run.waiting = (tat > slot_burst[pick]) ? tat - slot_burst[pick] : '0;
            tat_total = add_capped(tat_total, tat);
            wait_total = add_capped(wait_total, run.waiting);
            if (done_n != DONE_MAX)
               done_n = done_n + 1'b1;
            completions++;
         end
      end
      run.total_turnaround = tat_total;
      run.total_waiting = wait_total;
      run.all_done = (done_n == slots_active);
   endtask

   // Sample both channels and the register port on the rising edge
   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         for (int i = 0; i < PROCESSES; i++) begin
            slot_pri[i] = '0;
            slot_arrival[i] = '0;
            slot_burst[i] = '0;
            slot_left[i] = '0;
         end
         sched_time = '0;
         prev_slot = '0;
         prev_valid = 1'b0;
         done_n = '0;
         tat_total = '0;
         wait_total = '0;
         slots_active = COUNT_RESET;
         predicted_runs.delete();
      end else begin
         // check the response beat against the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (predicted_runs.size() == 0) begin
               log_mismatch($sformatf("response beat %0d with no request outstanding",
                                      rsp_beats));
            end else begin
               want = predicted_runs.pop_front();
               match_field("running_slot", 32'(rsp_mon.running_slot),
                           32'(want.running_slot));
               match_field("idle", 32'(rsp_mon.idle), 32'(want.idle));
               match_field("new_segment", 32'(rsp_mon.new_segment), 32'(want.new_segment));
               match_field("segment_start", 32'(rsp_mon.segment_start),
                           32'(want.segment_start));
               match_field("finished", 32'(rsp_mon.finished), 32'(want.finished));
               match_field("finish_time", 32'(rsp_mon.finish_time), 32'(want.finish_time));
               match_field("turnaround", 32'(rsp_mon.turnaround), 32'(want.turnaround));
               match_field("waiting", 32'(rsp_mon.waiting), 32'(want.waiting));
               match_field("total_turnaround", 32'(rsp_mon.total_turnaround),
                           32'(want.total_turnaround));
               match_field("total_waiting", 32'(rsp_mon.total_waiting),
                           32'(want.total_waiting));
               match_field("all_done", 32'(rsp_mon.all_done), 32'(want.all_done));
            end
            rsp_beats++;
         end
         if (csr_we)
            slots_active = csr_wdata;
         // predict the request beat taken at this edge
         if (req_mon.valid && req_mon.ready) begin
            advance_schedule(req_mon.command, req_mon.slot, req_mon.priority_req,
                             req_mon.arrival, req_mon.burst, want);
            predicted_runs.push_back(want);
         end
      end
      runs_outstanding = predicted_runs.size();
   end

endmodule

FILE: verif/tb_preemptive_priority_scheduler.sv
// Testbench top for the preemptive priority scheduler: clock, reset, request stimulus,
// register writes, response back-pressure and the verdict.
// Depends on pps_pkg, pps_channels, the scheduler RTL and pps_schedule_monitor.
module tb_preemptive_priority_scheduler;
   import pps_pkg::*;

   localparam int PHASE_ITEMS   = 180;
   localparam int HOLD_CYCLES   = 40;
   localparam int SETTLE_CYCLES = 20;
   localparam logic [COUNT_W-1:0] PHASE_COUNTS [8] =
      '{4'd1, 4'd8, 4'd3, 4'd0, 4'd15, 4'd6, 4'd2, 4'd8};

   logic               clock;
   logic               reset;
   logic               csr_we;
   logic [COUNT_W-1:0] csr_wdata;
   int                 mismatch_count;
   int                 runs_outstanding;
   int                 completions;
   bit                 gap_free;
   bit                 stall_free;
   bit                 hold_request;
   logic [TIME_W-1:0]  now_est;
   int                 load_total;
   int                 tick_total;
   int                 setting_total;

   pps_req_if req_ch();
   pps_rsp_if rsp_ch();

   preemptive_priority_scheduler dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_bus   (req_ch),
      .rsp_bus   (rsp_ch)
   );

   pps_schedule_monitor sched_mon (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_mon          (req_ch),
      .rsp_mon          (rsp_ch),
      .mismatch_count   (mismatch_count),
      .runs_outstanding (runs_outstanding),
      .completions      (completions)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #30_000_000;
      $display("preemptive_priority_scheduler regression: fail");
      $finish;
   end

   // Response back-pressure: random stall bursts, one long hold on request
   initial begin : rsp_pacing
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else if (!stall_free && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(0, 4)) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   function automatic logic [PRI_W-1:0] pick_priority();
      // favor a narrow range so ties come up often
      return ($urandom_range(0, 1) == 1) ? PRI_W'($urandom_range(0, 3))
                                         : PRI_W'($urandom_range(0, 255));
   endfunction

   // Offer one request beat, maybe after a gap, and hold it until taken
   task automatic offer_beat(input logic cmd, input logic [SLOT_FW-1:0] slot,
                             input logic [PRI_W-1:0] pri,
                             input logic [TIME_W-1:0] arrival,
                             input logic [TIME_W-1:0] burst);
      @(negedge clock);
      if (!gap_free && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.command <= cmd;
      req_ch.slot <= slot;
      req_ch.priority_req <= pri;
      req_ch.arrival <= arrival;
      req_ch.burst <= burst;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      if (cmd == CMD_TICK) begin
         tick_total++;
         if (now_est != TIME_MAX)
            now_est = now_est + 1'b1;
      end else begin
         load_total++;
      end
   endtask

   // Ticks ignore the payload, so fill it with noise
   task automatic offer_tick();
      offer_beat(CMD_TICK, SLOT_FW'($urandom), PRI_W'($urandom), TIME_W'($urandom),
                 TIME_W'($urandom));
   endtask

   // Drop valid and wait until every predicted response has been taken
   task automatic drain_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (runs_outstanding != 0) @(negedge clock);
   endtask

   task automatic set_process_count(input logic [COUNT_W-1:0] value);
      drain_results();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      setting_total++;
   endtask

   initial begin : stimulus
      int                n;
      int                m;
      int                phase_items;
      logic [TIME_W-1:0] arr;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.command = CMD_LOAD;
      req_ch.slot = '0;
      req_ch.priority_req = '0;
      req_ch.arrival = '0;
      req_ch.burst = '0;
      gap_free = 1'b0;
      stall_free = 1'b0;
      hold_request = 1'b0;
      now_est = '0;
      load_total = 0;
      tick_total = 0;
      setting_total = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: idle tick on an empty table
      offer_tick();
      // field extremes, zero burst, a late arrival and a priority tie
      offer_beat(CMD_LOAD, 3'd0, 8'd255, 16'd0, 16'd3);
      offer_beat(CMD_LOAD, 3'd7, 8'd0, TIME_MAX, TIME_MAX);
      offer_beat(CMD_LOAD, 3'd3, 8'd0, 16'd0, 16'd0);
      offer_beat(CMD_LOAD, 3'd1, 8'd9, 16'd1, 16'd1);
      offer_beat(CMD_LOAD, 3'd2, 8'd9, 16'd0, 16'd1);
      offer_beat(CMD_LOAD, 3'd4, 8'd9, 16'd5, 16'd1);
      // tie to the lower slot, then the low-urgency slot, then preemption at time 5
      repeat (6) offer_tick();
      // reload a finished slot and let it finish again
      offer_beat(CMD_LOAD, 3'd1, 8'd1, 16'd0, 16'd2);
      repeat (2) offer_tick();
      // nothing eligible left
      offer_tick();

      // Random phases, each under its own process count
      for (int ph = 0; ph < 8; ph++) begin
         set_process_count(PHASE_COUNTS[ph]);
         if (ph == 1)
            hold_request = 1'b1;
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) < 8) begin
               // well-formed: a few loads arriving soon, then ticks to run them
               n = $urandom_range(1, 8);
               repeat (n) begin
                  arr = (now_est > TIME_MAX - 16'd4) ? TIME_MAX
                                                     : now_est + TIME_W'($urandom_range(0, 4));
                  offer_beat(CMD_LOAD, SLOT_FW'($urandom_range(0, 7)), pick_priority(), arr,
                             ($urandom_range(0, 7) == 0) ? 16'd0
                                                         : TIME_W'($urandom_range(1, 4)));
               end
               m = $urandom_range(1, 12);
               repeat (m) offer_tick();
               phase_items += n + m;
            end else begin
               // noise: any command with any field values
               offer_beat(1'($urandom), SLOT_FW'($urandom), PRI_W'($urandom),
                          TIME_W'($urandom), TIME_W'($urandom));
               phase_items++;
            end
         end
      end

      // Last part, no idling: idle ticks with no slots taking part
      gap_free = 1'b1;
      stall_free = 1'b1;
      set_process_count(4'd0);
      repeat (8) offer_tick();

      // Full table reloads with long turnarounds keep the done count at its ceiling
      set_process_count(4'd8);
      repeat (2) begin
         for (int s = 0; s < 8; s++) begin
            offer_beat(CMD_LOAD, SLOT_FW'(s), pick_priority(),
                       TIME_W'($urandom_range(0, 64)), TIME_W'($urandom_range(1, 3)));
         end
         repeat (30) offer_tick();
      end
      set_process_count(4'd15);
      offer_tick();
      offer_beat(CMD_LOAD, 3'd5, 8'd3, 16'd0, 16'd2);

      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("covered %0d load beats and %0d tick beats over %0d process-count settings,",
               load_total, tick_total, setting_total);
      $display("with %0d completions checked, zero-count idle ticks and a long output hold",
               completions);
      if (mismatch_count == 0 && runs_outstanding == 0) begin
         $display("preemptive_priority_scheduler regression: pass");
      end else begin
         $display("%0d mismatches, %0d responses never arrived", mismatch_count,
                  runs_outstanding);
         $display("preemptive_priority_scheduler regression: fail");
      end
      $finish;
   end

endmodule

FILE: preemptive_priority_scheduler.f
design/pps_pkg.sv
design/pps_channels.sv
design/pps_store.sv
design/pps_out.sv
design/preemptive_priority_scheduler.sv
verif/pps_schedule_monitor.sv
verif/tb_preemptive_priority_scheduler.sv
